// File: sv/lsp_pkg.sv
// ============================================================================
// lsp_pkg: shared types and constants for the line segment prism extruder
// Holds field widths, fixed-point constants, pipeline depths and the item
// record that the datapath hands to the vertex emitter.
// ============================================================================
package lsp_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int HW_W      = 31;
	localparam int UNIT_W    = 31;
	localparam int MAG_W     = 64;
	localparam int OFF_W     = 33;
	localparam int DIFF_W    = 33;
	localparam int CORNER_W  = 3;

	localparam logic [HW_W-1:0] HW_RESET = HW_W'(1) << FRAC_BITS;

	localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(7);

	// Axis unit: input, normalize and square stages, then
	// one square-root step and one quotient bit per stage.
	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = UNIT_W;
	localparam int AXIS_LAT  = 7 + SQ_STEPS + DIV_STEPS;

	typedef logic [2:0][COORD_W-1:0] point_t;
	typedef logic [2:0][UNIT_W-1:0]  unit3_t;
	typedef logic [2:0][MAG_W-1:0]   mag3_t;
	typedef logic [2:0][OFF_W-1:0]   off3_t;

	typedef struct packed {
		point_t p0;
		point_t p1;
		off3_t  off_side;
		off3_t  off_up;
		logic   degen;
	} item_t;

endpackage

// File: sv/lsp_seg_if.sv
// ============================================================================
// lsp_seg_if: segment input channel
// Valid/ready channel carrying one line segment word.
// ============================================================================
interface lsp_seg_if;
	logic valid;
	logic ready;
	logic signed [lsp_pkg::COORD_W-1:0] start_x;
	logic signed [lsp_pkg::COORD_W-1:0] start_y;
	logic signed [lsp_pkg::COORD_W-1:0] start_z;
	logic signed [lsp_pkg::COORD_W-1:0] end_x;
	logic signed [lsp_pkg::COORD_W-1:0] end_y;
	logic signed [lsp_pkg::COORD_W-1:0] end_z;

	modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
		input ready);
	modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
		output ready);
endinterface

// File: sv/lsp_vert_if.sv
// ============================================================================
// lsp_vert_if: vertex output channel
// Valid/ready channel carrying one extruded vertex word.
// ============================================================================
interface lsp_vert_if;
	logic valid;
	logic ready;
	logic signed [lsp_pkg::COORD_W-1:0] vert_x;
	logic signed [lsp_pkg::COORD_W-1:0] vert_y;
	logic signed [lsp_pkg::COORD_W-1:0] vert_z;
	logic [lsp_pkg::CORNER_W-1:0] corner;
	logic degenerate;
	logic saturated;
	logic last;

	modport source (output valid, vert_x, vert_y, vert_z, corner, degenerate,
		saturated, last, input ready);
	modport sink (input valid, vert_x, vert_y, vert_z, corner, degenerate,
		saturated, last, output ready);
endinterface

// File: sv/lsp_delay.sv
// ============================================================================
// lsp_delay: enabled shift line
// Carries side data alongside a pipelined unit so both arrive together.
// ============================================================================
module lsp_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_s[i] <= tap_s[i-1];
			end
		end
	end

	assign dout = tap_s[DEPTH-1];

endmodule

// File: sv/lsp_axis.sv
// ============================================================================
// lsp_axis: pipelined vector normalizer
// Scales a 3-vector of magnitudes to Q1.30 unit length: block shift,
// sum of squares, one square-root step per stage, one quotient bit per stage.
// ============================================================================
module lsp_axis (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  lsp_pkg::mag3_t in_mag,
	output logic           out_valid,
	output lsp_pkg::unit3_t unit
);

	typedef struct packed {
		logic            zero;
		lsp_pkg::unit3_t m;
		logic [63:0]     s;
		logic [63:0]     r;
	} sq_t;

	typedef struct packed {
		logic            zero;
		logic [31:0]     n;
		logic [2:0][32:0] rem;
		lsp_pkg::unit3_t q;
	} dv_t;

	function automatic lsp_pkg::mag3_t shr_step(lsp_pkg::mag3_t m, int s);
		logic [63:0] all;
		lsp_pkg::mag3_t y;
		all = m[0] | m[1] | m[2];
		y = m;
		if ((all >> (30 + s)) != 64'd0) begin
			for (int c = 0; c < 3; c++) y[c] = m[c] >> s;
		end
		return y;
	endfunction

	function automatic lsp_pkg::mag3_t shl_step(lsp_pkg::mag3_t m, int s);
		logic [63:0] all;
		lsp_pkg::mag3_t y;
		all = m[0] | m[1] | m[2];
		y = m;
		if ((all >> (31 - s)) == 64'd0) begin
			for (int c = 0; c < 3; c++) y[c] = m[c] << s;
		end
		return y;
	endfunction

	function automatic sq_t sq_step(sq_t x, int i);
		logic [63:0] b;
		logic [63:0] t;
		sq_t y;
		b = 64'd1 << (62 - 2 * i);
		t = x.r + b;
		y = x;
		if (x.s >= t) begin
			y.s = x.s - t;
			y.r = (x.r >> 1) + b;
		end else begin
			y.r = x.r >> 1;
		end
		return y;
	endfunction

	function automatic dv_t dv_step(dv_t x, int k);
		logic [32:0] r;
		dv_t y;
		y = x;
		for (int c = 0; c < 3; c++) begin
			if (x.rem[c] >= {1'b0, x.n}) begin
				y.q[c][lsp_pkg::UNIT_W-1-k] = 1'b1;
				r = x.rem[c] - {1'b0, x.n};
			end else begin
				r = x.rem[c];
			end
			y.rem[c] = {r[31:0], 1'b0};
		end
		return y;
	endfunction

	localparam int LAT = lsp_pkg::AXIS_LAT;

	logic [LAT:1] vld_s;

	logic           z_s1, z_s2, z_s3, z_s4, z_s5, z_s6, z_s7;
	lsp_pkg::mag3_t m_s1, m_s2, m_s3, m_s4, m4n;
	lsp_pkg::unit3_t u_s5, u_s6, u_s7;
	logic [2:0][61:0] sq_s6;
	logic [63:0]    sum_s7;

	sq_t sq_in;
	sq_t sq_s [1:lsp_pkg::SQ_STEPS];
	dv_t dv_in;
	dv_t dv_s [1:lsp_pkg::DIV_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-1:1], in_valid};
		end
	end

	assign m4n = shl_step(shl_step(m_s4, 2), 1);

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1   <= (in_mag == '0);
			m_s1   <= in_mag;
			z_s2   <= z_s1;
			m_s2   <= shr_step(shr_step(shr_step(m_s1, 32), 16), 8);
			z_s3   <= z_s2;
			m_s3   <= shr_step(shr_step(shr_step(m_s2, 4), 2), 1);
			z_s4   <= z_s3;
			m_s4   <= shl_step(shl_step(shl_step(m_s3, 16), 8), 4);
			z_s5   <= z_s4;
			for (int c = 0; c < 3; c++) u_s5[c] <= m4n[c][lsp_pkg::UNIT_W-1:0];
			z_s6   <= z_s5;
			u_s6   <= u_s5;
			for (int c = 0; c < 3; c++) sq_s6[c] <= 62'(u_s5[c]) * 62'(u_s5[c]);
			z_s7   <= z_s6;
			u_s7   <= u_s6;
			sum_s7 <= 64'(sq_s6[0]) + 64'(sq_s6[1]) + 64'(sq_s6[2]);
		end
	end

	assign sq_in = '{zero: z_s7, m: u_s7, s: sum_s7, r: 64'd0};

	for (genvar i = 0; i < lsp_pkg::SQ_STEPS; i++) begin : g_sq
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) sq_s[1] <= sq_step(sq_in, 0);
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) sq_s[i+1] <= sq_step(sq_s[i], i);
			end
		end
	end

	always_comb begin
		dv_in.zero = sq_s[lsp_pkg::SQ_STEPS].zero;
		dv_in.n    = sq_s[lsp_pkg::SQ_STEPS].r[31:0];
		dv_in.q    = '0;
		for (int c = 0; c < 3; c++) begin
			dv_in.rem[c] = {2'b00, sq_s[lsp_pkg::SQ_STEPS].m[c]};
		end
	end

	for (genvar k = 0; k < lsp_pkg::DIV_STEPS; k++) begin : g_dv
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (en) dv_s[1] <= dv_step(dv_in, 0);
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) dv_s[k+1] <= dv_step(dv_s[k], k);
			end
		end
	end

	// A zero vector stays zero; its divide-by-zero quotient is discarded.
	assign unit      = dv_s[lsp_pkg::DIV_STEPS].zero ? '0 : dv_s[lsp_pkg::DIV_STEPS].q;
	assign out_valid = vld_s[LAT];

endmodule

// File: sv/lsp_emit.sv
// ============================================================================
// lsp_emit: vertex emitter
// Holds one finished segment and sends its eight vertices, one per cycle
// while the output is not back-pressured, through a registered output.
// ============================================================================
module lsp_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  lsp_pkg::item_t item,
	output logic           take,
	lsp_vert_if.source     vert
);

	localparam logic [lsp_pkg::COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
	localparam logic [lsp_pkg::COORD_W-1:0] COORD_MIN = 32'h8000_0000;

	logic busy_q;
	logic [lsp_pkg::CORNER_W-1:0] cnt_q;
	logic ov_q;
	lsp_pkg::item_t item_q;

	logic [2:0][lsp_pkg::COORD_W-1:0] vx_q;
	logic [lsp_pkg::CORNER_W-1:0] corner_q;
	logic degen_q, sat_q, last_q;

	logic load, at_last;
	lsp_pkg::off3_t off;
	lsp_pkg::point_t base;
	logic [2:0][lsp_pkg::COORD_W-1:0] vx;
	logic sat;
	logic [33:0] b34, o34, s34;

	assign load    = !ov_q || vert.ready;
	assign at_last = (cnt_q == lsp_pkg::LAST_CORNER);
	assign take    = !busy_q || (load && at_last);

	// Corner bit 2 picks the axis, bit 1 the offset sign, bit 0 the endpoint.
	always_comb begin
		off  = cnt_q[2] ? item_q.off_up : item_q.off_side;
		base = cnt_q[0] ? item_q.p1 : item_q.p0;
		sat  = 1'b0;
		b34  = '0;
		o34  = '0;
		s34  = '0;
		for (int c = 0; c < 3; c++) begin
			b34 = {{2{base[c][31]}}, base[c]};
			o34 = {off[c][32], off[c]};
			s34 = cnt_q[1] ? b34 + o34 : b34 - o34;
			if (s34[33:31] == 3'b000 || s34[33:31] == 3'b111) begin
				vx[c] = s34[31:0];
			end else begin
				vx[c] = s34[33] ? COORD_MIN : COORD_MAX;
				sat   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (load) ov_q <= busy_q;
			if (busy_q && load) begin
				cnt_q <= cnt_q + 1'b1;
				if (at_last) busy_q <= 1'b0;
			end
			if (in_valid && take) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && take) item_q <= item;
		if (busy_q && load) begin
			vx_q     <= vx;
			corner_q <= cnt_q;
			degen_q  <= item_q.degen;
			sat_q    <= sat;
			last_q   <= at_last;
		end
	end

	assign vert.valid      = ov_q;
	assign vert.vert_x     = vx_q[0];
	assign vert.vert_y     = vx_q[1];
	assign vert.vert_z     = vx_q[2];
	assign vert.corner     = corner_q;
	assign vert.degenerate = degen_q;
	assign vert.saturated  = sat_q;
	assign vert.last       = last_q;

endmodule

// File: sv/line_segment_prism_extrusion.sv
// ============================================================================
// line_segment_prism_extrusion: thick line prism extruder
// Turns one 3D segment into the eight vertices of an extruded prism.
// ============================================================================
// Each segment word on seg yields eight vertex words on vert, corners 0 to 7
// in order, the last one flagged. The side axis is (-dy, dx, 0) and the up
// axis is the side unit crossed with d, both scaled to unit length and then
// by half_width; each vertex is start or end plus or minus that offset,
// saturated to 32 bits. The datapath is a fully pipelined chain of 146
// register stages and accepts a word in any cycle in which it is not stalled,
// but the emitter sends one vertex per cycle while the output is not
// back-pressured, so the sustained rate is set by the single vertex output
// port. The half_width register resets to 1.0 and should be written only
// while no segment is in flight. A back-pressured output stalls the whole
// chain without loss.
// ============================================================================
module line_segment_prism_extrusion (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [lsp_pkg::HW_W-1:0] cfg_data,
	lsp_seg_if.sink                  seg,
	lsp_vert_if.source               vert
);

	typedef logic [2:0][lsp_pkg::DIFF_W-1:0] diff3_t;
	typedef logic [1:0][lsp_pkg::UNIT_W-1:0] unit2_t;

	// Side data that waits beside the side-axis normalizer.
	typedef struct packed {
		lsp_pkg::point_t p0;
		lsp_pkg::point_t p1;
		diff3_t          dm;
		logic [2:0]      dn;
		logic [1:0]      sn;
		logic            degen;
	} sba_t;

	// Side data that waits beside the up-axis normalizer.
	typedef struct packed {
		lsp_pkg::point_t p0;
		lsp_pkg::point_t p1;
		unit2_t          su;
		logic [1:0]      sn;
		logic [2:0]      un;
		logic            degen;
	} sbb_t;

	// Round the offset magnitude half up and apply the component sign.
	function automatic logic [lsp_pkg::OFF_W-1:0] rnd_off(logic [61:0] pr, logic neg);
		logic [62:0] t;
		logic [lsp_pkg::OFF_W-1:0] o;
		t = {1'b0, pr} + (63'd1 << 29);
		o = t[62:30];
		return neg ? -o : o;
	endfunction

	logic [lsp_pkg::HW_W-1:0] hw_q;

	logic en, take;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic va, vb;

	lsp_pkg::point_t p0_s1, p1_s1;
	diff3_t          d_s1;

	sba_t            sba_s2, sba_out;
	lsp_pkg::mag3_t  side_mag;
	lsp_pkg::unit3_t side_unit;

	sbb_t            sbb_s3;
	logic [3:0][63:0] pr_s3;
	diff3_t          dm_tmp;

	sbb_t            sbb_s4, sbb_out;
	lsp_pkg::mag3_t  up_mag_s4;
	lsp_pkg::unit3_t up_unit;

	sbb_t            sbb_s5;
	logic [4:0][61:0] op_s5;

	lsp_pkg::item_t  item_s6;

	logic [lsp_pkg::DIFF_W-1:0] d_in [3];

	// The chain advances unless a finished segment is waiting on the emitter.
	assign en        = !v_s6 || take;
	assign seg.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= lsp_pkg::HW_RESET;
		end else if (cfg_we) begin
			hw_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= seg.valid;
			v_s2 <= v_s1;
			v_s3 <= va;
			v_s4 <= v_s3;
			v_s5 <= vb;
			v_s6 <= v_s5;
		end
	end

	// Differences are exact in 33 bits.
	assign d_in[0] = {seg.end_x[31], seg.end_x} - {seg.start_x[31], seg.start_x};
	assign d_in[1] = {seg.end_y[31], seg.end_y} - {seg.start_y[31], seg.start_y};
	assign d_in[2] = {seg.end_z[31], seg.end_z} - {seg.start_z[31], seg.start_z};

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= {seg.start_z, seg.start_y, seg.start_x};
			p1_s1 <= {seg.end_z, seg.end_y, seg.end_x};
			for (int c = 0; c < 3; c++) d_s1[c] <= d_in[c];
		end
	end

	// Stage two: magnitudes and signs. The side axis is (-dy, dx, 0).
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dm_tmp[c] = d_s1[c][lsp_pkg::DIFF_W-1] ? -d_s1[c] : d_s1[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sba_s2.p0    <= p0_s1;
			sba_s2.p1    <= p1_s1;
			sba_s2.dm    <= dm_tmp;
			for (int c = 0; c < 3; c++) sba_s2.dn[c] <= d_s1[c][lsp_pkg::DIFF_W-1];
			sba_s2.sn[0] <= !d_s1[1][lsp_pkg::DIFF_W-1] && (d_s1[1] != '0);
			sba_s2.sn[1] <= d_s1[0][lsp_pkg::DIFF_W-1];
			sba_s2.degen <= (d_s1[0] == '0) && (d_s1[1] == '0);
		end
	end

	assign side_mag[0] = lsp_pkg::MAG_W'(sba_s2.dm[1]);
	assign side_mag[1] = lsp_pkg::MAG_W'(sba_s2.dm[0]);
	assign side_mag[2] = '0;

	lsp_axis u_side (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_mag    (side_mag),
		.out_valid (va),
		.unit      (side_unit)
	);

	lsp_delay #(
		.W     ($bits(sba_t)),
		.DEPTH (lsp_pkg::AXIS_LAT)
	) u_sba (
		.clk  (clk),
		.en   (en),
		.din  (sba_s2),
		.dout (sba_out)
	);

	// Stage three: partial products of side unit and d for the up axis.
	always_ff @(posedge clk) begin
		if (en) begin
			sbb_s3.p0    <= sba_out.p0;
			sbb_s3.p1    <= sba_out.p1;
			sbb_s3.su    <= {side_unit[1], side_unit[0]};
			sbb_s3.sn    <= sba_out.sn;
			sbb_s3.un[0] <= sba_out.sn[1] ^ sba_out.dn[2];
			sbb_s3.un[1] <= !(sba_out.sn[0] ^ sba_out.dn[2]);
			sbb_s3.un[2] <= 1'b1;
			sbb_s3.degen <= sba_out.degen;
			pr_s3[0]     <= 64'(side_unit[1]) * 64'(sba_out.dm[2]);
			pr_s3[1]     <= 64'(side_unit[0]) * 64'(sba_out.dm[2]);
			pr_s3[2]     <= 64'(side_unit[0]) * 64'(sba_out.dm[1]);
			pr_s3[3]     <= 64'(side_unit[1]) * 64'(sba_out.dm[0]);
		end
	end

	// Stage four: up vector magnitudes; z is the sum of two products.
	always_ff @(posedge clk) begin
		if (en) begin
			sbb_s4       <= sbb_s3;
			up_mag_s4[0] <= pr_s3[0];
			up_mag_s4[1] <= pr_s3[1];
			up_mag_s4[2] <= pr_s3[2] + pr_s3[3];
		end
	end

	lsp_axis u_up (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_mag    (up_mag_s4),
		.out_valid (vb),
		.unit      (up_unit)
	);

	lsp_delay #(
		.W     ($bits(sbb_t)),
		.DEPTH (lsp_pkg::AXIS_LAT)
	) u_sbb (
		.clk  (clk),
		.en   (en),
		.din  (sbb_s4),
		.dout (sbb_out)
	);

	// Stage five: scale every unit component by half_width.
	always_ff @(posedge clk) begin
		if (en) begin
			sbb_s5   <= sbb_out;
			op_s5[0] <= 62'(sbb_out.su[0]) * 62'(hw_q);
			op_s5[1] <= 62'(sbb_out.su[1]) * 62'(hw_q);
			for (int c = 0; c < 3; c++) op_s5[2+c] <= 62'(up_unit[c]) * 62'(hw_q);
		end
	end

	// Stage six: rounded, signed offsets ready for the emitter.
	always_ff @(posedge clk) begin
		if (en) begin
			item_s6.p0          <= sbb_s5.p0;
			item_s6.p1          <= sbb_s5.p1;
			item_s6.off_side[0] <= rnd_off(op_s5[0], sbb_s5.sn[0]);
			item_s6.off_side[1] <= rnd_off(op_s5[1], sbb_s5.sn[1]);
			item_s6.off_side[2] <= '0;
			for (int c = 0; c < 3; c++) begin
				item_s6.off_up[c] <= rnd_off(op_s5[2+c], sbb_s5.un[c]);
			end
			item_s6.degen       <= sbb_s5.degen;
		end
	end

	lsp_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s6),
		.item     (item_s6),
		.take     (take),
		.vert     (vert)
	);

endmodule
